### src/pdm_pkg.sv
// Shared constants, types and arctangent table for the polar disc mesh generator.
`timescale 1ns / 1ps
package pdm_pkg;

    localparam int NW           = 11;
    localparam int SCALE_W      = 16;
    localparam int IDX_W        = 20;
    localparam int POS_W        = 24;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 16;
    localparam int QUO_W        = 25;
    localparam int DIV_W        = NW + QUO_W;
    localparam int CQW          = 34;
    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = 5;
    localparam int MAG_W        = 32;
    localparam int RAD_W        = NW + SCALE_W;
    localparam int PROD_W       = RAD_W + MAG_W;
    localparam int POS_SHIFT    = 24;

    localparam logic [CQW-1:0]        CORDIC_GAIN = 34'h026DD3B6A;
    localparam logic [NW-1:0]         SEG_MIN     = 11'd20;
    localparam logic [NW-1:0]         SEG_RESET   = 11'd360;
    localparam logic [SCALE_W-1:0]    SCALE_MIN   = 16'd256;
    localparam logic [SCALE_W-1:0]    SCALE_RESET = 16'd256;
    localparam logic [CFG_IDX_W-1:0]  REG_SEG_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_DISC_SCALE = 4'd1;

    typedef struct packed {
        logic accept;
        logic phase_start;
        logic cordic_start;
        logic mul_en;
        logic pos_start;
        logic out_load;
    } pdm_cmd_t;

    typedef struct packed {
        logic div_done;
        logic cordic_done;
        logic out_free;
    } pdm_sts_t;

    function automatic logic [CQW-1:0] atan_turn(input logic [ITER_W-1:0] k);
        logic [CQW-1:0] a;
        case (k)
            5'd0:    a = 34'h020000000;
            5'd1:    a = 34'h012E4051D;
            5'd2:    a = 34'h009FB385B;
            5'd3:    a = 34'h0051111D4;
            5'd4:    a = 34'h0028B0D43;
            5'd5:    a = 34'h00145D7E1;
            5'd6:    a = 34'h000A2F61E;
            5'd7:    a = 34'h000517C55;
            5'd8:    a = 34'h00028BE53;
            5'd9:    a = 34'h000145F2E;
            5'd10:   a = 34'h0000A2F98;
            5'd11:   a = 34'h0000517CC;
            5'd12:   a = 34'h000028BE6;
            5'd13:   a = 34'h0000145F3;
            5'd14:   a = 34'h00000A2F9;
            5'd15:   a = 34'h00000517C;
            5'd16:   a = 34'h0000028BE;
            5'd17:   a = 34'h00000145F;
            5'd18:   a = 34'h000000A2F;
            5'd19:   a = 34'h000000517;
            5'd20:   a = 34'h00000028B;
            5'd21:   a = 34'h000000145;
            5'd22:   a = 34'h0000000A2;
            5'd23:   a = 34'h000000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### src/pdm_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pdm_div
    import pdm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [NW-1:0]     divisor,
    output logic              done,
    output logic [QUO_W-1:0]  quotient
);

    logic [NW-1:0]     rem_reg, rem_next;
    logic [QUO_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [NW:0]       trial;
    logic              ge;

    assign trial    = {rem_reg, dvd_reg[QUO_W-1]};
    assign ge       = trial >= {1'b0, divisor};
    assign rem_next = ge ? NW'(trial - {1'b0, divisor}) : trial[NW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= dividend[DIV_W-1:QUO_W];
                dvd_reg  <= dividend[QUO_W-1:0];
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ITER_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/pdm_ctrl.sv
// Sequencing state machine for the polar disc mesh generator.
`timescale 1ns / 1ps
module pdm_ctrl
    import pdm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pdm_sts_t sts,
    output pdm_cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PHASE = 8'b0000_0010,
        ST_DIVP  = 8'b0000_0100,
        ST_CORD  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_POSS  = 8'b0010_0000,
        ST_DIVQ  = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } pdm_state_t;

    pdm_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE: begin
                cmd.phase_start = 1'b1;
                state_next      = ST_DIVP;
            end
            ST_DIVP: begin
                if (sts.div_done) begin
                    cmd.cordic_start = 1'b1;
                    state_next       = ST_CORD;
                end
            end
            ST_CORD: begin
                if (sts.cordic_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_POSS;
            end
            ST_POSS: begin
                cmd.pos_start = 1'b1;
                state_next    = ST_DIVQ;
            end
            ST_DIVQ: begin
                if (sts.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/pdm_datapath.sv
// Counters, configuration, dividers, CORDIC and output register of the mesh generator.
`timescale 1ns / 1ps
module pdm_datapath
    import pdm_pkg::*;
#(
    parameter int MAX_SEGMENTS = 1024,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_restart,
    input  pdm_cmd_t               cmd,
    output pdm_sts_t               sts,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic signed [POS_W-1:0] m_pos_x,
    output logic signed [POS_W-1:0] m_pos_z,
    output logic [IDX_W-1:0]       m_vertex_number,
    output logic [IDX_W-1:0]       m_tri_a0,
    output logic [IDX_W-1:0]       m_tri_a1,
    output logic [IDX_W-1:0]       m_tri_a2,
    output logic [IDX_W-1:0]       m_tri_b0,
    output logic [IDX_W-1:0]       m_tri_b1,
    output logic [IDX_W-1:0]       m_tri_b2,
    output logic                   m_tris_valid,
    output logic                   m_mesh_last
);

    localparam int SEG_CAP = (MAX_SEGMENTS > 2047) ? 2047 : MAX_SEGMENTS;

    logic [NW-1:0]      seg_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [NW-1:0]      ring_reg, rad_reg;
    logic [NW-1:0]      cur_j_reg;
    logic [NW-1:0]      cur_i_reg;
    logic [IDX_W-1:0]   base_reg, nbase_reg;
    logic               trisv_reg, last_reg;
    logic [RAD_W-1:0]   radnum_reg;

    logic [NW-1:0]      seg_wr;
    logic [NW-1:0]      i_sel, j_sel, next_i;
    logic               hit, j_last, i_last;
    logic [2*NW-1:0]    base_full, nbase_full;

    assign seg_wr = (cfg_data[NW-1:0] < SEG_MIN) ? SEG_MIN :
                    (cfg_data[NW-1:0] > NW'(SEG_CAP)) ? NW'(SEG_CAP) : cfg_data[NW-1:0];

    assign hit    = s_restart || (ring_reg >= seg_reg) || (rad_reg >= seg_reg);
    assign i_sel  = hit ? '0 : ring_reg;
    assign j_sel  = hit ? '0 : rad_reg;
    assign j_last = ({1'b0, j_sel} + 1'b1) == {1'b0, seg_reg};
    assign i_last = ({1'b0, i_sel} + 1'b1) == {1'b0, seg_reg};
    assign next_i = i_last ? '0 : NW'(i_sel + 1'b1);
    assign base_full  = (2*NW)'(i_sel) * (2*NW)'(seg_reg);
    assign nbase_full = (2*NW)'(next_i) * (2*NW)'(seg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg   <= SEG_RESET;
            scale_reg <= SCALE_RESET;
            ring_reg  <= '0;
            rad_reg   <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SEG_COUNT:  seg_reg <= seg_wr;
                    REG_DISC_SCALE: scale_reg <= (cfg_data < SCALE_MIN) ? SCALE_MIN : cfg_data;
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                if (j_last) begin
                    rad_reg  <= '0;
                    ring_reg <= next_i;
                end else begin
                    rad_reg  <= NW'(j_sel + 1'b1);
                    ring_reg <= i_sel;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cur_i_reg  <= i_sel;
            cur_j_reg  <= j_sel;
            base_reg   <= base_full[IDX_W-1:0];
            nbase_reg  <= nbase_full[IDX_W-1:0];
            trisv_reg  <= !j_last;
            last_reg   <= j_last && i_last;
            radnum_reg <= RAD_W'(j_sel) * RAD_W'(scale_reg);
        end
    end

    // dividers: x unit also computes the phase
    logic [DIV_W-1:0] phase_dvd, x_dvd, z_dvd, xdiv_dvd;
    logic             xdiv_done, zdiv_done;
    logic [QUO_W-1:0] xdiv_q, zdiv_q;
    logic [PROD_W-1:0] px_reg, pz_reg;
    logic              negx_reg, negz_reg;
    logic [PROD_W:0]   round_add;
    logic [PROD_W:0]   x_sum, z_sum;

    assign phase_dvd = (DIV_W'(cur_i_reg) << ANGLE_BITS) + DIV_W'(seg_reg >> 1);
    assign round_add = (PROD_W+1)'(seg_reg) << (POS_SHIFT - 1);
    assign x_sum     = (PROD_W+1)'(px_reg) + round_add;
    assign z_sum     = (PROD_W+1)'(pz_reg) + round_add;
    assign x_dvd     = x_sum[POS_SHIFT +: DIV_W];
    assign z_dvd     = z_sum[POS_SHIFT +: DIV_W];
    assign xdiv_dvd  = cmd.phase_start ? phase_dvd : x_dvd;

    pdm_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.phase_start | cmd.pos_start),
        .dividend (xdiv_dvd),
        .divisor  (seg_reg),
        .done     (xdiv_done),
        .quotient (xdiv_q)
    );

    pdm_div u_div_z (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.pos_start),
        .dividend (z_dvd),
        .divisor  (seg_reg),
        .done     (zdiv_done),
        .quotient (zdiv_q)
    );

    // CORDIC
    logic signed [CQW-1:0] cx_reg, cy_reg, cz_reg;
    logic [1:0]            quad_reg;
    logic [ITER_W-1:0]     k_reg;
    logic                  cbusy_reg, cdone_reg;
    logic [31:0]           phase32;
    logic signed [CQW-1:0] dx, dy, atan_k;
    logic signed [CQW-1:0] cos_v, sin_v, abs_c, abs_s;

    assign phase32 = {xdiv_q[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
    assign dx      = cy_reg >>> k_reg;
    assign dy      = cx_reg >>> k_reg;
    assign atan_k  = atan_turn(k_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cbusy_reg <= 1'b0;
            cdone_reg <= 1'b0;
            k_reg     <= '0;
        end else begin
            cdone_reg <= 1'b0;
            if (cmd.cordic_start) begin
                cbusy_reg <= 1'b1;
                k_reg     <= '0;
                cx_reg    <= CORDIC_GAIN;
                cy_reg    <= '0;
                cz_reg    <= CQW'(phase32[29:0]);
                quad_reg  <= phase32[31:30];
            end else if (cbusy_reg) begin
                if (!cz_reg[CQW-1]) begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - atan_k;
                end else begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + atan_k;
                end
                k_reg <= k_reg + 1'b1;
                if (k_reg == ITER_W'(CORDIC_ITERS - 1)) begin
                    cbusy_reg <= 1'b0;
                    cdone_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (quad_reg)
            2'd0:    begin cos_v = cx_reg;  sin_v = cy_reg;  end
            2'd1:    begin cos_v = -cy_reg; sin_v = cx_reg;  end
            2'd2:    begin cos_v = -cx_reg; sin_v = -cy_reg; end
            default: begin cos_v = cy_reg;  sin_v = -cx_reg; end
        endcase
    end

    assign abs_c = cos_v[CQW-1] ? -cos_v : cos_v;
    assign abs_s = sin_v[CQW-1] ? -sin_v : sin_v;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            px_reg   <= PROD_W'(radnum_reg) * PROD_W'(abs_c[MAG_W-1:0]);
            pz_reg   <= PROD_W'(radnum_reg) * PROD_W'(abs_s[MAG_W-1:0]);
            negx_reg <= cos_v[CQW-1];
            negz_reg <= sin_v[CQW-1];
        end
    end

    // output register
    logic [QUO_W-1:0] qx, qz;
    logic [IDX_W-1:0] vtx, vtx1, nb, nb1;
    logic             mvalid_reg;

    assign qx   = negx_reg ? QUO_W'(-xdiv_q) : xdiv_q;
    assign qz   = negz_reg ? QUO_W'(-zdiv_q) : zdiv_q;
    assign vtx  = base_reg + IDX_W'(cur_j_reg);
    assign vtx1 = vtx + 1'b1;
    assign nb   = nbase_reg + IDX_W'(cur_j_reg);
    assign nb1  = nb + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_ready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_pos_x         <= qx[POS_W-1:0];
            m_pos_z         <= qz[POS_W-1:0];
            m_vertex_number <= vtx;
            m_tri_a0        <= trisv_reg ? vtx  : '0;
            m_tri_a1        <= trisv_reg ? nb   : '0;
            m_tri_a2        <= trisv_reg ? nb1  : '0;
            m_tri_b0        <= trisv_reg ? vtx  : '0;
            m_tri_b1        <= trisv_reg ? nb1  : '0;
            m_tri_b2        <= trisv_reg ? vtx1 : '0;
            m_tris_valid    <= trisv_reg;
            m_mesh_last     <= last_reg;
        end
    end

    assign m_valid         = mvalid_reg;
    assign sts.div_done    = xdiv_done & (zdiv_done | ~cmd.pos_start);
    assign sts.cordic_done = cdone_reg;
    assign sts.out_free    = !mvalid_reg || m_ready;

endmodule

### src/polar_disc_mesh_generator.sv
// Top level of the polar disc mesh generator.
`timescale 1ns / 1ps
// Each accepted request emits one vertex of an N by N polar grid, radial step
// fastest, with its index and the two triangles joining it to the next ring.
// A request takes two passes of a bit-serial divider by N (phase first, then
// x and z in parallel) and a 24-step CORDIC. One request is in work at a time;
// a finished vertex waits in the output register while the next request is
// accepted. Configuration writes are accepted every cycle and are meant to be
// issued while the block is idle.
module polar_disc_mesh_generator
    import pdm_pkg::*;
#(
    parameter int MAX_SEGMENTS = 1024,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_restart,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [POS_W-1:0] m_pos_x,
    output logic signed [POS_W-1:0] m_pos_z,
    output logic [IDX_W-1:0]        m_vertex_number,
    output logic [IDX_W-1:0]        m_tri_a0,
    output logic [IDX_W-1:0]        m_tri_a1,
    output logic [IDX_W-1:0]        m_tri_a2,
    output logic [IDX_W-1:0]        m_tri_b0,
    output logic [IDX_W-1:0]        m_tri_b1,
    output logic [IDX_W-1:0]        m_tri_b2,
    output logic                    m_tris_valid,
    output logic                    m_mesh_last
);

    pdm_cmd_t cmd;
    pdm_sts_t sts;

    assign cfg_ready = 1'b1;

    pdm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pdm_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_restart       (s_restart),
        .cmd             (cmd),
        .sts             (sts),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_pos_x         (m_pos_x),
        .m_pos_z         (m_pos_z),
        .m_vertex_number (m_vertex_number),
        .m_tri_a0        (m_tri_a0),
        .m_tri_a1        (m_tri_a1),
        .m_tri_a2        (m_tri_a2),
        .m_tri_b0        (m_tri_b0),
        .m_tri_b1        (m_tri_b1),
        .m_tri_b2        (m_tri_b2),
        .m_tris_valid    (m_tris_valid),
        .m_mesh_last     (m_mesh_last)
    );

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in work");

    a_no_tris_on_rim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tris_valid |-> m_tri_a0 == '0 && m_tri_a1 == '0 &&
            m_tri_a2 == '0 && m_tri_b0 == '0 && m_tri_b1 == '0 && m_tri_b2 == '0)
        else $error("triangle indices on outer radial step");

    a_tri_anchor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tris_valid |-> m_tri_a0 == m_vertex_number &&
            m_tri_b0 == m_vertex_number && m_tri_a2 == m_tri_b1)
        else $error("triangle corners disagree with vertex");

    a_last_on_rim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mesh_last |-> !m_tris_valid)
        else $error("last vertex carries triangles");

endmodule
